// File: rtl/port_bitmap_allocator_core_defines.svh
// Assertion macros for the port bitmap allocator.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef PORT_BITMAP_ALLOCATOR_CORE_DEFINES_SVH
`define PORT_BITMAP_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PBA_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PBA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define PBA_ASSERT(label, clk, rstn, prop, msg)
`define PBA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

// File: rtl/pba_pkg.sv
// Shared constants, codes and types of the port bitmap allocator.
// No dependencies; used by the interfaces, pba_word_scan and the allocator core.
package pba_pkg;

  localparam int PORT_W     = 16;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int PORT_COUNT = 65536;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = (PORT_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_IDX_W = $clog2(MAP_WORDS);
  localparam int BIT_IDX_W  = $clog2(WORD_BITS);
  localparam int CNT_W      = PORT_W + 1;
  localparam int TAIL_BITS  = PORT_COUNT - (MAP_WORDS - 1) * WORD_BITS;

  localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(MAP_WORDS - 1);
  localparam logic [WORD_BITS-1:0]  TAIL_MASK =
      {WORD_BITS{1'b1}} >> (WORD_BITS - TAIL_BITS);
  localparam logic [CNT_W-1:0]      PORT_LIMIT = CNT_W'(PORT_COUNT);

  localparam logic [PORT_W-1:0] LAST_RESET  = 16'd49151;
  localparam logic [PORT_W-1:0] FIRST_RESET = 16'd49152;

  localparam logic [CMD_W-1:0] CMD_ALLOC_DYN  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC_SPEC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE       = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_IN_USE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_PORT = 2'd2;

  typedef struct packed {
    logic [BIT_IDX_W-1:0] lo;
    logic                 hi_en;
    logic [BIT_IDX_W-1:0] hi;
    logic                 tail;
  } scan_ctl_t;

  typedef struct packed {
    logic                 found;
    logic [BIT_IDX_W-1:0] idx;
    logic [WORD_BITS-1:0] word_set;
  } scan_res_t;

endpackage

// File: rtl/pba_cfg_if.sv
// Configuration write channel: dynamic range base register.
// Depends on pba_pkg.
interface pba_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [pba_pkg::PORT_W-1:0] dynamic_first_port;

  modport source(output valid, dynamic_first_port, input ready);
  modport sink(input valid, dynamic_first_port, output ready);
endinterface

// File: rtl/pba_req_if.sv
// Request channel: command and port number.
// Depends on pba_pkg.
interface pba_req_if;
  logic                       valid;
  logic                       ready;
  logic [pba_pkg::CMD_W-1:0]  command;
  logic [pba_pkg::PORT_W-1:0] port_number;

  modport source(output valid, command, port_number, input ready);
  modport sink(input valid, command, port_number, output ready);
endinterface

// File: rtl/pba_rsp_if.sv
// Response channel: resulting port and status.
// Depends on pba_pkg.
interface pba_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [pba_pkg::PORT_W-1:0]   result_port;
  logic [pba_pkg::STATUS_W-1:0] status;

  modport source(output valid, result_port, status, input ready);
  modport sink(input valid, result_port, status, output ready);
endinterface

// File: rtl/pba_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/pba_word_scan.sv
// Free-bit search over one map word within lower, upper and tail bounds.
// Depends on pba_pkg.
module pba_word_scan (
  input  logic [pba_pkg::WORD_BITS-1:0] word_i,
  input  pba_pkg::scan_ctl_t            ctl_i,
  output pba_pkg::scan_res_t            res_o
);

  localparam int WB  = pba_pkg::WORD_BITS;
  localparam int BIW = pba_pkg::BIT_IDX_W;

  logic [WB-1:0]  lo_mask;
  logic [WB-1:0]  hi_mask;
  logic [WB-1:0]  tail_mask;
  logic [WB-1:0]  avail;
  logic [WB-1:0]  onehot;
  logic [BIW-1:0] idx;

  assign lo_mask   = {WB{1'b1}} << ctl_i.lo;
  assign hi_mask   = ctl_i.hi_en ? ~({WB{1'b1}} << ctl_i.hi) : {WB{1'b1}};
  assign tail_mask = ctl_i.tail ? pba_pkg::TAIL_MASK : {WB{1'b1}};
  assign avail     = ~word_i & lo_mask & hi_mask & tail_mask;
  assign onehot    = avail & (~avail + {{(WB-1){1'b0}}, 1'b1});

  always_comb begin
    idx = '0;
    for (int i = 0; i < WB; i++) begin
      if (onehot[i]) begin
        idx = idx | BIW'(i);
      end
    end
  end

  assign res_o.found    = |avail;
  assign res_o.idx      = idx;
  assign res_o.word_set = word_i | onehot;

endmodule

// File: rtl/port_bitmap_allocator_core.sv
// Port bitmap allocator: after reset a clearing pass writes every map word to
// zero, during which no request is taken (configuration writes are).
// Each request is then served alone. Allocate-specific, free and the unused
// command read the word from the map memory, then modify it, write it back and
// register the result. A dynamic allocation reads the start word and then
// further 32-bit words in its next-fit search, one word per cycle through the
// map memory read port; at most 2049 words are read. A request is taken while
// an earlier result still waits in the output register.
// Depends on pba_pkg, the channel interfaces, pba_ram, pba_word_scan and
// port_bitmap_allocator_core_defines.svh.
`include "port_bitmap_allocator_core_defines.svh"

module port_bitmap_allocator_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  pba_cfg_if.sink           cfg_i,
  pba_req_if.sink           req_i,
  pba_rsp_if.source         rsp_o
);

  localparam int PW  = pba_pkg::PORT_W;
  localparam int WIW = pba_pkg::WORD_IDX_W;
  localparam int BIW = pba_pkg::BIT_IDX_W;
  localparam int WB  = pba_pkg::WORD_BITS;
  localparam int CW  = pba_pkg::CNT_W;
  localparam int SW  = pba_pkg::STATUS_W;
  localparam int MW  = pba_pkg::CMD_W;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EVAL} state_e;

  function automatic logic [WIW-1:0] word_of(input logic [PW-1:0] p);
    return WIW'(p >> BIW);
  endfunction

  function automatic logic [BIW-1:0] bit_of(input logic [PW-1:0] p);
    return p[BIW-1:0];
  endfunction

  state_e          state_q, state_d;
  logic [WIW-1:0]  clr_addr_q, clr_addr_d;
  logic [MW-1:0]   cmd_q, cmd_d;
  logic [PW-1:0]   port_q, port_d;
  logic [WIW-1:0]  word_q, word_d;
  logic [PW-1:0]   start_q, start_d;
  logic            first_visit_q, first_visit_d;
  logic            wrapped_q, wrapped_d;
  logic [PW-1:0]   last_q, last_d;
  logic [PW-1:0]   first_q, first_d;
  logic            out_valid_q, out_valid_d;
  logic [PW-1:0]   out_port_q, out_port_d;
  logic [SW-1:0]   out_status_q, out_status_d;

  logic            ram_we, ram_re;
  logic [WIW-1:0]  ram_waddr, ram_raddr;
  logic [WB-1:0]   ram_wdata, rd_word;

  pba_pkg::scan_ctl_t scan_ctl;
  pba_pkg::scan_res_t scan_res;

  logic            req_fire;
  logic            out_free;
  logic            done_now;
  logic [CW-1:0]   cand_ext;
  logic [PW-1:0]   cand;
  logic            dyn_empty;
  logic            port_in_map;
  logic [WIW-1:0]  first_word, start_word;
  logic [BIW-1:0]  first_bit, start_bit;
  logic            at_end;
  logic [WB-1:0]   bit_mask;

  logic            fin;
  logic [PW-1:0]   fin_port;
  logic [SW-1:0]   fin_status;
  logic            fin_we;
  logic [WB-1:0]   fin_wdata;
  logic            fin_last;
  logic [PW-1:0]   fin_last_val;

  pba_ram #(
    .WIDTH(WB),
    .DEPTH(pba_pkg::MAP_WORDS)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rd_word)
  );

  pba_word_scan u_scan (
    .word_i(rd_word),
    .ctl_i (scan_ctl),
    .res_o (scan_res)
  );

  assign req_i.ready       = (state_q == ST_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.result_port = out_port_q;
  assign rsp_o.status      = out_status_q;

  assign req_fire  = req_i.valid && req_i.ready;
  assign out_free  = !out_valid_q || rsp_o.ready;

  assign cand_ext  = {1'b0, last_q} + {{(CW-1){1'b0}}, 1'b1};
  assign cand      = (cand_ext >= pba_pkg::PORT_LIMIT || cand_ext < {1'b0, first_q})
                   ? first_q : cand_ext[PW-1:0];
  assign dyn_empty = ({1'b0, first_q} >= pba_pkg::PORT_LIMIT);
  assign port_in_map = ({1'b0, port_q} < pba_pkg::PORT_LIMIT);

  assign first_word = word_of(first_q);
  assign first_bit  = bit_of(first_q);
  assign start_word = word_of(start_q);
  assign start_bit  = bit_of(start_q);
  assign at_end     = wrapped_q && (word_q == start_word);
  assign bit_mask   = {{(WB-1){1'b0}}, 1'b1} << bit_of(port_q);

  always_comb begin
    scan_ctl.lo    = first_visit_q ? start_bit
                   : ((word_q == first_word) ? first_bit : '0);
    scan_ctl.hi_en = at_end;
    scan_ctl.hi    = start_bit;
    scan_ctl.tail  = (word_q == pba_pkg::LAST_WORD);
  end

  always_comb begin
    state_d       = state_q;
    clr_addr_d    = clr_addr_q;
    cmd_d         = cmd_q;
    port_d        = port_q;
    word_d        = word_q;
    start_d       = start_q;
    first_visit_d = first_visit_q;
    wrapped_d     = wrapped_q;
    last_d        = last_q;
    first_d       = first_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;
    out_port_d    = out_port_q;
    out_status_d  = out_status_q;

    ram_we    = 1'b0;
    ram_waddr = word_q;
    ram_wdata = rd_word;
    ram_re    = 1'b0;
    ram_raddr = word_q;
    done_now  = 1'b0;

    fin          = 1'b0;
    fin_port     = '0;
    fin_status   = pba_pkg::STATUS_DONE;
    fin_we       = 1'b0;
    fin_wdata    = rd_word;
    fin_last     = 1'b0;
    fin_last_val = last_q;

    if (cfg_i.valid && cfg_i.ready) begin
      first_d = cfg_i.dynamic_first_port;
    end

    unique case (state_q)
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = '0;
        clr_addr_d = clr_addr_q + {{(WIW-1){1'b0}}, 1'b1};
        if (clr_addr_q == pba_pkg::LAST_WORD) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_fire) begin
          cmd_d         = req_i.command;
          port_d        = req_i.port_number;
          start_d       = cand;
          first_visit_d = 1'b1;
          wrapped_d     = 1'b0;
          ram_re        = 1'b1;
          ram_raddr     = (req_i.command == pba_pkg::CMD_ALLOC_DYN)
                        ? word_of(cand) : word_of(req_i.port_number);
          word_d        = ram_raddr;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        unique case (cmd_q)
          pba_pkg::CMD_ALLOC_DYN: begin
            if (dyn_empty) begin
              fin        = 1'b1;
              fin_status = pba_pkg::STATUS_NO_PORT;
            end else if (scan_res.found) begin
              fin          = 1'b1;
              fin_port     = PW'({word_q, scan_res.idx});
              fin_we       = 1'b1;
              fin_wdata    = scan_res.word_set;
              fin_last     = 1'b1;
              fin_last_val = PW'({word_q, scan_res.idx});
            end else if (at_end) begin
              fin          = 1'b1;
              fin_status   = pba_pkg::STATUS_NO_PORT;
              fin_last     = 1'b1;
              fin_last_val = start_q;
            end else begin
              first_visit_d = 1'b0;
              ram_re        = 1'b1;
              if (word_q == pba_pkg::LAST_WORD) begin
                ram_raddr = first_word;
                wrapped_d = 1'b1;
              end else begin
                ram_raddr = word_q + {{(WIW-1){1'b0}}, 1'b1};
              end
              word_d = ram_raddr;
            end
          end
          pba_pkg::CMD_ALLOC_SPEC: begin
            fin      = 1'b1;
            fin_port = port_q;
            if (!port_in_map || (rd_word & bit_mask) != '0) begin
              fin_status = pba_pkg::STATUS_IN_USE;
            end else begin
              fin_we    = 1'b1;
              fin_wdata = rd_word | bit_mask;
            end
          end
          pba_pkg::CMD_FREE: begin
            fin       = 1'b1;
            fin_port  = port_q;
            fin_we    = port_in_map;
            fin_wdata = rd_word & ~bit_mask;
          end
          default: begin
            fin = 1'b1;
          end
        endcase

        if (fin && out_free) begin
          done_now     = 1'b1;
          ram_we       = fin_we;
          ram_wdata    = fin_wdata;
          out_valid_d  = 1'b1;
          out_port_d   = fin_port;
          out_status_d = fin_status;
          state_d      = ST_IDLE;
          if (fin_last) begin
            last_d = fin_last_val;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_addr_q    <= '0;
      cmd_q         <= '0;
      port_q        <= '0;
      word_q        <= '0;
      start_q       <= '0;
      first_visit_q <= 1'b0;
      wrapped_q     <= 1'b0;
      last_q        <= pba_pkg::LAST_RESET;
      first_q       <= pba_pkg::FIRST_RESET;
      out_valid_q   <= 1'b0;
      out_port_q    <= '0;
      out_status_q  <= pba_pkg::STATUS_DONE;
    end else begin
      state_q       <= state_d;
      clr_addr_q    <= clr_addr_d;
      cmd_q         <= cmd_d;
      port_q        <= port_d;
      word_q        <= word_d;
      start_q       <= start_d;
      first_visit_q <= first_visit_d;
      wrapped_q     <= wrapped_d;
      last_q        <= last_d;
      first_q       <= first_d;
      out_valid_q   <= out_valid_d;
      out_port_q    <= out_port_d;
      out_status_q  <= out_status_d;
    end
  end

  `PBA_ASSERT(a_no_rw_same_cycle, clk_i, rst_ni, !(ram_we && ram_re), "map read and write overlap")
  `PBA_ASSERT_NEXT(a_accept_to_eval, clk_i, rst_ni, req_fire, state_q == ST_EVAL, "request not evaluated")
  `PBA_ASSERT(a_dyn_in_range, clk_i, rst_ni, (done_now && cmd_q == pba_pkg::CMD_ALLOC_DYN && out_status_d == pba_pkg::STATUS_DONE) |-> (out_port_d >= first_q), "dynamic port below range")

endmodule
